FILE: hdl/ttsf_pkg.sv
`default_nettype none
package ttsf_pkg;

  localparam int SampleWidth = 16;

  // Weighted sums are five times the result; the magnitude plus the rounding
  // offset needs three bits above the sample.
  localparam int SumWidth   = SampleWidth + 4;
  localparam int MagWidth   = SampleWidth + 3;
  localparam int RecipShift = MagWidth + 3;
  localparam int RecipWidth = RecipShift - 1;
  localparam int ProdWidth  = MagWidth + RecipWidth;

  // ceil(2^RecipShift / 5)
  localparam logic [RecipWidth-1:0] RecipFive =
      RecipWidth'(((64'd1 << RecipShift) + 64'd4) / 64'd5);

  localparam int FifoDepth = 4;
  localparam int PtrWidth  = $clog2(FifoDepth);
  localparam int CntWidth  = PtrWidth + 1;

  localparam logic [1:0] SeenNone = 2'd0;
  localparam logic [1:0] SeenOne  = 2'd1;
  localparam logic [1:0] SeenMany = 2'd2;

  typedef struct packed {
    logic signed [SampleWidth-1:0] sample;
    logic                          frame_end;
  } in_word_t;

  typedef struct packed {
    logic signed [SampleWidth-1:0] smoothed;
    logic                          frame_done;
  } out_word_t;

  // Divide by five, rounding to nearest, ties away from zero.
  function automatic logic signed [SampleWidth-1:0] div_five(
      input logic signed [SumWidth-1:0] n);
    logic [SumWidth-1:0]    mag;
    logic [MagWidth-1:0]    m;
    logic [ProdWidth-1:0]   p;
    logic [SampleWidth-1:0] q;
    mag = n[SumWidth-1] ? (~n + SumWidth'(1)) : n;
    m   = mag[MagWidth-1:0] + MagWidth'(2);
    p   = ProdWidth'(m) * ProdWidth'(RecipFive);
    q   = p[RecipShift+SampleWidth-1:RecipShift];
    return n[SumWidth-1] ? (~q + SampleWidth'(1)) : q;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/three_tap_smoothing_filter_core.sv
`default_nettype none
// Three-tap smoothing filter (weights 1/5, 3/5, 1/5; frame edges use 4/5 and
// 1/5) over a framed stream of signed samples. One word is taken per cycle.
// Each word is held in an input register, then filtered and rounded by
// combinational logic into a four-entry result queue, which the output side
// reads; results are written to the queue when the held word moves on.
// Results lag the input by one sample: the first word of a frame yields
// nothing, every later word yields one result, and the frame's last word
// yields two (the pending sample and the closing edge sample, flagged
// frame_done). A one-word frame passes its sample through. A frame yields as
// many results as it has words, so with the output side taking a word every
// cycle the queue never holds more than two and the input never stalls. The
// input stalls only while the queue lacks room for two results, which
// happens only when the output side holds off.
module three_tap_smoothing_filter_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  input  wire ttsf_pkg::in_word_t  in_word_i,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output ttsf_pkg::out_word_t      out_word_o
);
  import ttsf_pkg::*;

  // input register
  logic     in_valid_q;
  in_word_t in_word_q;

  // delay line
  logic signed [SampleWidth-1:0] older_q, newer_q;
  logic [1:0]                    seen_q;

  // result queue
  out_word_t             fifo_q [FifoDepth];
  logic [PtrWidth-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntWidth-1:0]   cnt_q;

  logic                          advance, fire, pop, push0, push1;
  logic                          first;
  logic signed [SumWidth-1:0]    s_ext, newer_ext, older_ext;
  logic signed [SumWidth-1:0]    sum0, sum1;
  out_word_t                     res0, res1;
  logic [1:0]                    n_push;

  // Room for two results decides whether the held word can move on.
  assign advance    = (cnt_q <= CntWidth'(FifoDepth - 2));
  assign fire       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  assign out_valid_o = (cnt_q != '0);
  assign out_word_o  = fifo_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;

  assign first     = (seen_q == SeenNone);
  assign s_ext     = SumWidth'(in_word_q.sample);
  assign newer_ext = SumWidth'(newer_q);
  assign older_ext = SumWidth'(older_q);

  always_comb begin
    // count pattern three behaves as two
    if (seen_q == SeenOne) begin
      sum0 = (newer_ext <<< 2) + s_ext;
    end else begin
      sum0 = older_ext + (newer_ext <<< 1) + newer_ext + s_ext;
    end
    sum1 = (s_ext <<< 2) + newer_ext;

    res0.smoothed   = first ? in_word_q.sample : div_five(sum0);
    res0.frame_done = first && in_word_q.frame_end;
    res1.smoothed   = div_five(sum1);
    res1.frame_done = 1'b1;

    push0  = fire && (!first || in_word_q.frame_end);
    push1  = fire && !first && in_word_q.frame_end;
    n_push = {1'b0, push0} + {1'b0, push1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      older_q    <= '0;
      newer_q    <= '0;
      seen_q     <= SeenNone;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        if (in_word_q.frame_end) begin
          older_q <= '0;
          newer_q <= '0;
          seen_q  <= SeenNone;
        end else if (first) begin
          newer_q <= in_word_q.sample;
          seen_q  <= SeenOne;
        end else begin
          older_q <= newer_q;
          newer_q <= in_word_q.sample;
          seen_q  <= SeenMany;
        end
      end
      wr_ptr_q <= wr_ptr_q + PtrWidth'(n_push);
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrWidth'(1);
      end
      cnt_q <= cnt_q + CntWidth'(n_push) - CntWidth'(pop);
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
    if (push0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push1) begin
      fifo_q[wr_ptr_q + PtrWidth'(1)] <= res1;
    end
  end

endmodule
`default_nettype wire
